// File: sv/lea_ks_pkg.sv
// Shared types, constants and helper functions of the LEA key schedule.
package lea_ks_pkg;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  typedef struct packed {
    logic [2:0] delta_sel;
    logic [4:0] delta_rot;
    logic [2:0] word_sel;
  } lea_ks_upd_ctl_t;

  function automatic logic [31:0] delta_word(input logic [2:0] idx);
    logic [31:0] d;
    case (idx)
      3'd0:    d = 32'hc3efe9db;
      3'd1:    d = 32'h44626b02;
      3'd2:    d = 32'h79e27c8a;
      3'd3:    d = 32'h78df30ec;
      3'd4:    d = 32'h715ea49e;
      3'd5:    d = 32'hc785da0a;
      3'd6:    d = 32'he04ef22a;
      3'd7:    d = 32'he5c40957;
      default: d = 32'hc3efe9db;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [2:0] j);
    logic [4:0] r;
    case (j)
      3'd0:    r = 5'd1;
      3'd1:    r = 5'd3;
      3'd2:    r = 5'd6;
      3'd3:    r = 5'd11;
      3'd4:    r = 5'd13;
      3'd5:    r = 5'd17;
      default: r = 5'd1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] t;
    t = {v, v} << r;
    return t[63:32];
  endfunction

  // Index of the last key word, which is also the last delta index.
  function automatic logic [2:0] last_word_idx(input logic [1:0] mode);
    logic [2:0] n;
    case (mode)
      MODE_128: n = 3'd3;
      MODE_192: n = 3'd5;
      default:  n = 3'd7;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] last_col(input logic [1:0] mode);
    return (mode == MODE_128) ? 3'd3 : 3'd5;
  endfunction

  function automatic logic [4:0] last_round_idx(input logic [1:0] mode);
    logic [4:0] n;
    case (mode)
      MODE_128: n = 5'd23;
      MODE_192: n = 5'd27;
      default:  n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

// File: sv/lea_ks_ifs.sv
// Handshake channel interfaces of the LEA key schedule.
interface lea_ks_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] key_length_mode;
  modport source (output valid, output key_length_mode, input ready);
  modport sink (input valid, input key_length_mode, output ready);
endinterface

interface lea_ks_key_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_word;
  modport source (output valid, output key_word, input ready);
  modport sink (input valid, input key_word, output ready);
endinterface

interface lea_ks_rk_if;
  logic        valid;
  logic        ready;
  logic [4:0]  round_index;
  logic [31:0] round_key_0;
  logic [31:0] round_key_1;
  logic [31:0] round_key_2;
  logic [31:0] round_key_3;
  logic [31:0] round_key_4;
  logic [31:0] round_key_5;
  logic        last_round;
  modport source (output valid, output round_index, output round_key_0,
                  output round_key_1, output round_key_2, output round_key_3,
                  output round_key_4, output round_key_5, output last_round,
                  input ready);
  modport sink (input valid, input round_index, input round_key_0,
                input round_key_1, input round_key_2, input round_key_3,
                input round_key_4, input round_key_5, input last_round,
                output ready);
endinterface

// File: sv/lea_ks_update.sv
// Shared word update: add the rotated delta, then apply the fixed rotation.
module lea_ks_update (
  input  logic [31:0]               state_word,
  input  lea_ks_pkg::lea_ks_upd_ctl_t ctl,
  output logic [31:0]               new_word
);
  import lea_ks_pkg::*;

  logic [31:0] delta_rot;
  logic [31:0] sum;

  assign delta_rot = rotl32(delta_word(ctl.delta_sel), ctl.delta_rot);
  assign sum       = state_word + delta_rot;
  assign new_word  = rotl32(sum, rot_amt(ctl.word_sel));

endmodule

// File: sv/lea_key_schedule_unit.sv
// LEA key schedule: collects a 4, 6 or 8 word master key and emits its round keys.
// Key words are taken one per cycle in ST_LOAD while cfg_ch.valid is low; the last word
// starts the expansion. Each round updates its 4 or 6 words in turn, then emits in ST_EMIT.
// A single adder-and-rotator update unit serves every word; output stalls hold the schedule.
// Synchronous active-low reset clears the sequencer, counters, mode (128-bit) and output valid.
module lea_key_schedule_unit (
  input logic         clk,
  input logic         rst_n,
  lea_ks_cfg_if.sink  cfg_ch,
  lea_ks_key_if.sink  in_ch,
  lea_ks_rk_if.source out_ch
);
  import lea_ks_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  words_r, words_nxt;
  logic [4:0]  round_r, round_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [2:0]  didx_r, didx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_round_r;
  logic        out_last_r;
  logic [31:0] out_rk_r [6];
  logic [31:0] key_r [8];
  logic [31:0] buf_r [6];

  logic        in_acc, cfg_acc, out_free, emit, is_256;
  logic [2:0]  last_idx, last_j;
  logic [4:0]  last_rnd;
  logic [31:0] upd_word;
  lea_ks_upd_ctl_t ctl;

  assign is_256   = mode_r[1];
  assign last_idx = last_word_idx(mode_r);
  assign last_j   = last_col(mode_r);
  assign last_rnd = last_round_idx(mode_r);

  assign cfg_ch.ready = (state_r == ST_LOAD) && !out_valid_r;
  assign in_ch.ready  = (state_r == ST_LOAD) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign emit         = (state_r == ST_EMIT) && out_free;

  assign ctl.delta_sel = didx_r;
  assign ctl.delta_rot = round_r + {2'b00, j_r};
  assign ctl.word_sel  = j_r;

  lea_ks_update u_update (
    .state_word (key_r[slot_r]),
    .ctl        (ctl),
    .new_word   (upd_word)
  );

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    words_nxt = words_r;
    round_nxt = round_r;
    j_nxt     = j_r;
    slot_nxt  = slot_r;
    didx_nxt  = didx_r;
    if (cfg_acc) begin
      mode_nxt  = cfg_ch.key_length_mode;
      words_nxt = 3'd0;
    end
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (words_r == last_idx) begin
            state_nxt = ST_RUN;
            words_nxt = 3'd0;
            round_nxt = 5'd0;
            j_nxt     = 3'd0;
            slot_nxt  = 3'd0;
            didx_nxt  = 3'd0;
          end else begin
            words_nxt = words_r + 3'd1;
          end
        end
      end
      ST_RUN: begin
        // The 256-bit schedule walks the eight working words continuously.
        if (j_r == last_j) begin
          state_nxt = ST_EMIT;
          j_nxt     = 3'd0;
          slot_nxt  = is_256 ? slot_r + 3'd1 : 3'd0;
        end else begin
          j_nxt    = j_r + 3'd1;
          slot_nxt = slot_r + 3'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          didx_nxt = (didx_r == last_idx) ? 3'd0 : didx_r + 3'd1;
          if (round_r == last_rnd) begin
            state_nxt = ST_LOAD;
            round_nxt = 5'd0;
          end else begin
            state_nxt = ST_RUN;
            round_nxt = round_r + 5'd1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      mode_r      <= MODE_128;
      words_r     <= 3'd0;
      round_r     <= 5'd0;
      j_r         <= 3'd0;
      slot_r      <= 3'd0;
      didx_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      words_r     <= words_nxt;
      round_r     <= round_nxt;
      j_r         <= j_nxt;
      slot_r      <= slot_nxt;
      didx_r      <= didx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r[words_r] <= in_ch.key_word;
    end else if (state_r == ST_RUN) begin
      key_r[slot_r] <= upd_word;
    end
    if (state_r == ST_RUN) begin
      buf_r[j_r] <= upd_word;
    end
  end

  // The 128-bit round key repeats T1 in words 1, 3 and 5.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_round_r <= round_r;
      out_last_r  <= (round_r == last_rnd);
      if (mode_r == MODE_128) begin
        out_rk_r[0] <= buf_r[0];
        out_rk_r[1] <= buf_r[1];
        out_rk_r[2] <= buf_r[2];
        out_rk_r[3] <= buf_r[1];
        out_rk_r[4] <= buf_r[3];
        out_rk_r[5] <= buf_r[1];
      end else begin
        out_rk_r[0] <= buf_r[0];
        out_rk_r[1] <= buf_r[1];
        out_rk_r[2] <= buf_r[2];
        out_rk_r[3] <= buf_r[3];
        out_rk_r[4] <= buf_r[4];
        out_rk_r[5] <= buf_r[5];
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.round_index = out_round_r;
  assign out_ch.round_key_0 = out_rk_r[0];
  assign out_ch.round_key_1 = out_rk_r[1];
  assign out_ch.round_key_2 = out_rk_r[2];
  assign out_ch.round_key_3 = out_rk_r[3];
  assign out_ch.round_key_4 = out_rk_r[4];
  assign out_ch.round_key_5 = out_rk_r[5];
  assign out_ch.last_round  = out_last_r;

`ifndef NO_ASSERTIONS
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && words_r == last_idx) |=> (state_r == ST_RUN))
    else $error("expansion did not start after the last key word");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_round_r == last_rnd))
    else $error("last round flag on the wrong round index");

  a_slot_col: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && !is_256) |-> (slot_r == j_r))
    else $error("working word slot out of step with the column");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (j_r <= last_j))
    else $error("column counter past the last word of the round");
`endif

endmodule
